>>> sv/maps_pkg.sv
package maps_pkg;

	// Window length default and field widths
	localparam int WINDOW_LEN_DEF = 20;
	localparam int CODE_W         = 12;
	localparam int PSI_W          = 8;
	localparam int MBAR_W         = 14;

	// Stream data widths, padded to whole bytes
	localparam int IN_TDATA_W  = ((CODE_W + 7) / 8) * 8;
	localparam int OUT_W       = CODE_W + PSI_W + MBAR_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_W;

	// Pressure in MPa, 20 fraction bits, at most 1.2 MPa
	localparam int FX_W = 21;

	// Code to MPa slope: SLOPE_NUM / SLOPE_DEN, split into whole and remainder parts
	localparam int SLOPE_NUM   = 1572707;
	localparam int SLOPE_DEN   = (1 << CODE_W) - 1;
	localparam int SLOPE_INT   = SLOPE_NUM / SLOPE_DEN;
	localparam int SLOPE_REM   = SLOPE_NUM % SLOPE_DEN;
	localparam int SLOPE_INT_W = FX_W - CODE_W;
	localparam int SLOPE_REM_W = 8;
	localparam int REM_PROD_W  = CODE_W + SLOPE_REM_W;

	localparam int OFFSET_FX  = 157286;
	localparam int MPA_MAX_FX = 1258291;

	// Output conversions
	localparam int PSI_FX       = 152083366;
	localparam int PSI_K_W      = 28;
	localparam int PSI_SHIFT    = 40;
	localparam int MBAR_PER_MPA = 10000;
	localparam int MBAR_K_W     = 14;
	localparam int MBAR_SHIFT   = 20;

	// Upper bounds on the output fields
	localparam int PSI_MAX  = 174;
	localparam int MBAR_MAX = 12000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_START,
		ST_DIV,
		ST_SCALE,
		ST_EMIT
	} maps_state_t;

	typedef struct packed {
		logic [MBAR_W-1:0] mbar;
		logic [PSI_W-1:0]  psi;
		logic [CODE_W-1:0] mean;
	} maps_result_t;

endpackage

>>> sv/maps_window.sv
module maps_window #(
	parameter int WINDOW_LEN = maps_pkg::WINDOW_LEN_DEF,
	parameter int CNT_W      = $clog2(WINDOW_LEN + 1),
	parameter int SUM_W      = $clog2(WINDOW_LEN * ((1 << maps_pkg::CODE_W) - 1) + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [maps_pkg::CODE_W-1:0] code,
	input  logic                        upd,
	output logic [SUM_W-1:0]            sum,
	output logic [CNT_W-1:0]            count
);
	import maps_pkg::*;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

	logic [CODE_W-1:0] mem [WINDOW_LEN];
	logic [CODE_W-1:0] old_q;
	logic [CODE_W-1:0] code_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic              full;

	assign full = (count_q == CNT_W'(WINDOW_LEN));

	// Read the leaving code on the transfer, write the new one in the following cycle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			old_q  <= mem[slot_q];
			code_q <= code;
		end
		if (upd) begin
			mem[slot_q] <= code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
		end else if (upd) begin
			if (full) begin
				sum_q <= sum_q + SUM_W'(code_q) - SUM_W'(old_q);
			end else begin
				sum_q   <= sum_q + SUM_W'(code_q);
				count_q <= count_q + CNT_W'(1);
			end
			if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + SLOT_W'(1);
			end
		end
	end

	assign sum   = sum_q;
	assign count = count_q;

endmodule

>>> sv/maps_div.sv
module maps_div #(
	parameter int NUM_W = 17,
	parameter int DEN_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);
	import maps_pkg::*;

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  nq_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [DEN_W:0]    shifted;
	logic [DEN_W+1:0]  diff;
	logic              ge;

	// One quotient bit a cycle, restoring form
	assign shifted = {rem_q, nq_q[NUM_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};
	assign ge      = !diff[DEN_W+1];

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q  <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			nq_q  <= {nq_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (start) begin
				step_q <= STEP_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = nq_q;

endmodule

>>> sv/maps_scale.sv
module maps_scale (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [maps_pkg::CODE_W-1:0] mean,
	output logic                        out_vld,
	output maps_pkg::maps_result_t      res
);
	import maps_pkg::*;

	localparam logic [SLOPE_INT_W-1:0] K_INT  = SLOPE_INT_W'(SLOPE_INT);
	localparam logic [SLOPE_REM_W-1:0] K_REM  = SLOPE_REM_W'(SLOPE_REM);
	localparam logic [PSI_K_W-1:0]     K_PSI  = PSI_K_W'(PSI_FX);
	localparam logic [MBAR_K_W-1:0]    K_MBAR = MBAR_K_W'(MBAR_PER_MPA);

	logic                              v_s1, v_s2, v_s3;
	logic [CODE_W-1:0]                 mean_s1, mean_s2, mean_s3;
	logic [FX_W-1:0]                   base_s1;
	logic [REM_PROD_W-1:0]             lo_s1;
	logic [FX_W-1:0]                   p_s2;
	logic [FX_W+PSI_K_W-1:0]           psi_s3;
	logic [FX_W+MBAR_K_W-1:0]          mbar_s3;

	logic [SLOPE_REM_W-1:0]            q0;
	logic [CODE_W:0]                   r;
	logic [SLOPE_REM_W-1:0]            q;
	logic [FX_W-1:0]                   scaled;
	logic [FX_W-1:0]                   p_next;

	// Divide by 2^12-1: y = q0*4096 + lo = q0*4095 + (lo + q0), one correction
	assign q0     = lo_s1[REM_PROD_W-1:CODE_W];
	assign r      = {1'b0, lo_s1[CODE_W-1:0]} + (CODE_W + 1)'(q0);
	assign q      = q0 + SLOPE_REM_W'(r >= (CODE_W + 1)'(SLOPE_DEN));
	assign scaled = base_s1 + FX_W'(q);

	always_comb begin
		if (scaled <= FX_W'(OFFSET_FX)) begin
			p_next = '0;
		end else if (scaled - FX_W'(OFFSET_FX) > FX_W'(MPA_MAX_FX)) begin
			p_next = FX_W'(MPA_MAX_FX);
		end else begin
			p_next = scaled - FX_W'(OFFSET_FX);
		end
	end

	always_ff @(posedge clk) begin
		mean_s1 <= mean;
		base_s1 <= FX_W'(mean) * FX_W'(K_INT);
		lo_s1   <= REM_PROD_W'(mean) * REM_PROD_W'(K_REM);
		mean_s2 <= mean_s1;
		p_s2    <= p_next;
		if (v_s2) begin
			mean_s3 <= mean_s2;
			psi_s3  <= (FX_W + PSI_K_W)'(p_s2) * (FX_W + PSI_K_W)'(K_PSI);
			mbar_s3 <= (FX_W + MBAR_K_W)'(p_s2) * (FX_W + MBAR_K_W)'(K_MBAR);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign out_vld  = v_s3;
	assign res.mean = mean_s3;
	assign res.psi  = psi_s3[PSI_SHIFT+PSI_W-1:PSI_SHIFT];
	assign res.mbar = mbar_s3[MBAR_SHIFT+MBAR_W-1:MBAR_SHIFT];

endmodule

>>> sv/moving_average_pressure_scaler.sv
// Per item: take input (ST_IDLE), update window (ST_LOAD), start divide (ST_START),
// divide (ST_DIV), scale (ST_SCALE), load output register (ST_EMIT, waiting while a full
// output register is stalled). One item at a time; the bit-serial divide by the fill
// count (NUM_W steps, NUM_W = bits of window sum plus half count) is the longest step.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n low, asynchronous): window empty, sum and fill count zero, no output valid.
// The sample memory itself is not cleared; an entry's old value is only used once written.
module moving_average_pressure_scaler #(
	parameter int WINDOW_LEN = maps_pkg::WINDOW_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [maps_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [11:0] sample, rest ignored
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [maps_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [11:0] mean_code,
	                                                         // [19:12] pressure_psi,
	                                                         // [33:20] pressure_millibar,
	                                                         // [39:34] zero
);
	import maps_pkg::*;

	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = $clog2(WINDOW_LEN * ((1 << CODE_W) - 1) + 1);
	// Numerator of the rounded mean: sum plus half the count
	localparam int NUM_W = $clog2(WINDOW_LEN * ((1 << CODE_W) - 1) + WINDOW_LEN / 2 + 1);

	maps_state_t       state_q, state_d;

	logic              in_xfer;
	logic              upd;
	logic              div_start;
	logic              sc_in_vld;
	logic              out_load;

	logic [SUM_W-1:0]  sum;
	logic [CNT_W-1:0]  count;
	logic              div_done;
	logic [NUM_W-1:0]  quot;
	logic [NUM_W-1:0]  num;
	logic              sc_vld;
	maps_result_t      sc_res;

	logic              m_valid_q;
	maps_result_t      m_res_q;

	// Window memory with running sum and fill count
	maps_window #(
		.WINDOW_LEN (WINDOW_LEN),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (in_xfer),
		.code   (s_axis_tdata[CODE_W-1:0]),
		.upd    (upd),
		.sum    (sum),
		.count  (count)
	);

	// Rounded mean: (sum + count/2) / count, count is at least one here
	assign num = NUM_W'(sum) + NUM_W'(count >> 1);

	maps_div #(
		.NUM_W (NUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (count),
		.done   (div_done),
		.quot   (quot)
	);

	// Linear map to pressure, clamp, then psi and millibar
	maps_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (sc_in_vld),
		.mean    (quot[CODE_W-1:0]),
		.out_vld (sc_vld),
		.res     (sc_res)
	);

	// Sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				state_d = ST_START;
			end
			ST_START: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (sc_vld) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// Hold until the output register is free or being drained
				if (!m_valid_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer: outputs
	always_comb begin
		s_axis_tready = 1'b0;
		upd           = 1'b0;
		div_start     = 1'b0;
		sc_in_vld     = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_LOAD:  upd           = 1'b1;
			ST_START: div_start     = 1'b1;
			ST_DIV:   sc_in_vld     = div_done;
			ST_SCALE: ;
			ST_EMIT:  out_load      = !m_valid_q || m_axis_tready;
			default:  ;
		endcase
	end

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register: refill on load, drop valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_res_q <= sc_res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, m_res_q};

endmodule

>>> sv/maps_chk.sv
module maps_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [maps_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import maps_pkg::*;

	logic in_xfer;

	assign in_xfer = s_axis_tvalid && s_axis_tready;

	// The block works on one item at a time: tready stays low through ST_LOAD and ST_START after a transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_axis_tready ##1 !s_axis_tready)
		else $error("input taken again too soon after a transfer");

	// A waiting result is neither lost nor altered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled output changed or dropped");

	// Clamped pressure stays inside the sensor span
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[CODE_W+PSI_W-1:CODE_W] <= PSI_W'(PSI_MAX) &&
			m_axis_tdata[OUT_W-1:CODE_W+PSI_W] <= MBAR_W'(MBAR_MAX))
		else $error("pressure outside the clamped span");

	// Padding above the packed fields stays zero
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:OUT_W] == '0)
		else $error("output padding bits set");

endmodule

bind moving_average_pressure_scaler maps_chk u_maps_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> verif/moving_average_pressure_scaler_tb.sv
module moving_average_pressure_scaler_tb;

	import maps_pkg::*;

	localparam int RING_LEN     = 20;
	localparam int SPARE_W      = IN_TDATA_W - CODE_W;
	localparam int SETTLE_CYCLES = 40;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1560;
	localparam int MAX_REPORTS  = 10;

	// Pressure scaling, MPa with 20 fraction bits
	localparam longint unsigned CODE_TO_MPA_NUM = 1572707;
	localparam longint unsigned CODE_TO_MPA_DEN = 4095;
	localparam longint unsigned SPAN_OFFSET     = 157286;
	localparam longint unsigned SPAN_TOP        = 1258291;
	localparam longint unsigned MPA_TO_PSI      = 152083366;
	localparam longint unsigned MPA_TO_MBAR     = 10000;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [11:0] sample, [15:12] spare
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [11:0] mean_code, [19:12] pressure_psi,
	                                        // [33:20] pressure_millibar, [39:34] zero

	// Window model of the scaler
	logic [CODE_W-1:0] ring_codes [RING_LEN];
	int unsigned       ring_slot;
	int unsigned       ring_fill;
	int unsigned       ring_sum;

	maps_result_t pending_readings[$];
	int unsigned  mismatch_count;
	int unsigned  burst_left;
	int unsigned  cycle_count;
	int unsigned  rx_cycle;

	moving_average_pressure_scaler u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Add one code to the window and queue the reading it should produce
	task automatic advance_window(input logic [CODE_W-1:0] code);
		int unsigned     mean;
		longint unsigned scaled;
		longint unsigned mpa;
		maps_result_t    reading;
		if (ring_fill < RING_LEN) begin
			ring_sum  = ring_sum + code;
			ring_fill = ring_fill + 1;
		end else begin
			// full window: the oldest code leaves before the new one lands
			ring_sum = ring_sum + code - ring_codes[ring_slot];
		end
		ring_codes[ring_slot] = code;
		ring_slot = (ring_slot + 1) % RING_LEN;

		mean   = ((ring_sum + ring_fill / 2) / ring_fill) & 32'hFFF;
		scaled = (longint'(mean) * CODE_TO_MPA_NUM) / CODE_TO_MPA_DEN;
		mpa    = (scaled <= SPAN_OFFSET) ? 0 : scaled - SPAN_OFFSET;
		if (mpa > SPAN_TOP)
			mpa = SPAN_TOP;

		reading.mean = mean[CODE_W-1:0];
		reading.psi  = PSI_W'((mpa * MPA_TO_PSI) >> 40);
		reading.mbar = MBAR_W'((mpa * MPA_TO_MBAR) >> 20);
		pending_readings.push_back(reading);
	endtask

	task automatic note_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("%0t: mismatch: %s", $realtime, what);
	endtask

	// Compare one output transfer with the oldest queued reading
	always @(posedge clk) begin
		maps_result_t got;
		maps_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = maps_result_t'(m_axis_tdata[OUT_W-1:0]);
			if (pending_readings.size() == 0) begin
				note_mismatch($sformatf("unexpected reading, data %h", m_axis_tdata));
			end else begin
				want = pending_readings.pop_front();
				if (got.mean !== want.mean)
					note_mismatch($sformatf("mean_code expected %0d got %0d",
						want.mean, got.mean));
				if (got.psi !== want.psi)
					note_mismatch($sformatf("pressure_psi expected %0d got %0d",
						want.psi, got.psi));
				if (got.mbar !== want.mbar)
					note_mismatch($sformatf("pressure_millibar expected %0d got %0d",
						want.mbar, got.mbar));
				if (m_axis_tdata[OUT_TDATA_W-1:OUT_W] !== '0)
					note_mismatch($sformatf("padding expected zero got %h",
						m_axis_tdata[OUT_TDATA_W-1:OUT_W]));
			end
		end
	end

	// Receiver back-pressure: cycle through free-running, light, blocky and heavy stalls
	initial begin
		m_axis_tready = 1'b0;
		rx_cycle      = 0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			case ((rx_cycle / 600) % 4)
				0: begin
					m_axis_tready <= 1'b1;
				end
				1: begin
					m_axis_tready <= ($urandom_range(0, 3) != 0);
				end
				2: begin
					m_axis_tready <= (((rx_cycle / 11) % 3) != 0);
				end
				default: begin
					m_axis_tready <= ($urandom_range(0, 1) != 0);
				end
			endcase
		end
	end

	// Watchdog
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("moving_average_pressure_scaler_tb: FAIL");
		$finish;
	end

	// Offer one sample; called and returns at a falling edge
	task automatic send_sample(input logic [CODE_W-1:0] code, input logic [SPARE_W-1:0] spare);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {spare, code};
		do @(posedge clk); while (!s_axis_tready);
		advance_window(code);
		@(negedge clk);
	endtask

	// Drop valid and hold until every queued reading has been seen
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_readings.size() != 0)
			@(negedge clk);
	endtask

	// Empty window, filling to full, wrap-round eviction and both clamps
	task automatic test_directed_window_fill();
		send_sample(12'h000, '1);       // lowest code, spare bits all set
		repeat (RING_LEN) send_sample(12'hFFF, '0);
		send_sample(12'h000, 4'h5);
		send_sample(12'h000, 4'hA);
		send_sample(12'h800, '1);
		send_sample(12'h7FF, '0);
	endtask

	// Pause until the pipeline is empty, then resume back to back
	task automatic test_pause_and_resume();
		repeat (12) send_sample(CODE_W'($urandom_range(0, 4095)), SPARE_W'($urandom));
		hold_until_drained();
		burst_left = 40;
		repeat (30) send_sample(CODE_W'($urandom_range(0, 4095)), SPARE_W'($urandom));
		hold_until_drained();
	endtask

	// Mostly slow-moving levels so the mean sweeps the whole span, with noise mixed in
	task automatic test_level_runs_random();
		int unsigned sent;
		int unsigned run_len;
		int unsigned style;
		int          level;
		int          code;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			style   = $urandom_range(0, 9);
			run_len = $urandom_range(5, 45);
			level   = $urandom_range(0, 4095);
			repeat (run_len) begin
				if (style <= 6)
					code = level + $urandom_range(0, 128) - 64;
				else if (style <= 8)
					code = $urandom_range(0, 4095);
				else
					code = ($urandom_range(0, 1) != 0) ? 4095 : 0;
				if (code < 0)
					code = 0;
				if (code > 4095)
					code = 4095;
				send_sample(CODE_W'(code), SPARE_W'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		ring_slot      = 0;
		ring_fill      = 0;
		ring_sum       = 0;
		mismatch_count = 0;
		burst_left     = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_window_fill();
		test_pause_and_resume();
		test_level_runs_random();

		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("moving_average_pressure_scaler_tb: PASS");
		else
			$display("moving_average_pressure_scaler_tb: FAIL");
		$finish;
	end

endmodule
